// ----- rtl/sgrap_pkg.sv -----
`timescale 1ns / 1ps

package sgrap_pkg;

    // Longest parameter run that the parser accounts for.
    localparam int MAX_PARAMS = 16;

    localparam int COLOR_W = 25;
    localparam int PARAM_W = 16;
    localparam int AFTER_W = 4;
    localparam int ATTR_W  = 8;

    // Reset values of the color registers.
    localparam logic [COLOR_W-1:0] FG_RESET = 25'd7;
    localparam logic [COLOR_W-1:0] BG_RESET = 25'd0;

    // Register map of the configuration port.
    localparam logic REG_DEFAULT_FG = 1'b0;
    localparam logic REG_DEFAULT_BG = 1'b1;

    // SGR parameter codes.
    localparam logic [PARAM_W-1:0] SGR_RESET         = 16'd0;
    localparam logic [PARAM_W-1:0] SGR_BOLD          = 16'd1;
    localparam logic [PARAM_W-1:0] SGR_FAINT         = 16'd2;
    localparam logic [PARAM_W-1:0] SGR_ITALIC        = 16'd3;
    localparam logic [PARAM_W-1:0] SGR_UNDERLINE     = 16'd4;
    localparam logic [PARAM_W-1:0] SGR_BLINK_SLOW    = 16'd5;
    localparam logic [PARAM_W-1:0] SGR_BLINK_FAST    = 16'd6;
    localparam logic [PARAM_W-1:0] SGR_REVERSE       = 16'd7;
    localparam logic [PARAM_W-1:0] SGR_INVISIBLE     = 16'd8;
    localparam logic [PARAM_W-1:0] SGR_STRUCK        = 16'd9;
    localparam logic [PARAM_W-1:0] SGR_DBL_UNDERLINE = 16'd21;
    localparam logic [PARAM_W-1:0] SGR_NORMAL_INT    = 16'd22;
    localparam logic [PARAM_W-1:0] SGR_NO_ITALIC     = 16'd23;
    localparam logic [PARAM_W-1:0] SGR_NO_UNDERLINE  = 16'd24;
    localparam logic [PARAM_W-1:0] SGR_NO_BLINK      = 16'd25;
    localparam logic [PARAM_W-1:0] SGR_NO_REVERSE    = 16'd27;
    localparam logic [PARAM_W-1:0] SGR_NO_INVISIBLE  = 16'd28;
    localparam logic [PARAM_W-1:0] SGR_NO_STRUCK     = 16'd29;
    localparam logic [PARAM_W-1:0] SGR_FG_FIRST      = 16'd30;
    localparam logic [PARAM_W-1:0] SGR_FG_LAST       = 16'd37;
    localparam logic [PARAM_W-1:0] SGR_EXT_FG        = 16'd38;
    localparam logic [PARAM_W-1:0] SGR_DEF_FG        = 16'd39;
    localparam logic [PARAM_W-1:0] SGR_BG_FIRST      = 16'd40;
    localparam logic [PARAM_W-1:0] SGR_BG_LAST       = 16'd47;
    localparam logic [PARAM_W-1:0] SGR_EXT_BG        = 16'd48;
    localparam logic [PARAM_W-1:0] SGR_DEF_BG        = 16'd49;
    localparam logic [PARAM_W-1:0] SGR_FG_BRT_FIRST  = 16'd90;
    localparam logic [PARAM_W-1:0] SGR_FG_BRT_LAST   = 16'd97;
    localparam logic [PARAM_W-1:0] SGR_BG_BRT_FIRST  = 16'd100;
    localparam logic [PARAM_W-1:0] SGR_BG_BRT_LAST   = 16'd107;

    // Extended color kinds.
    localparam logic [PARAM_W-1:0] KIND_RGB   = 16'd2;
    localparam logic [PARAM_W-1:0] KIND_INDEX = 16'd5;

    // Parameters that must follow each kind.
    localparam logic [AFTER_W-1:0] RGB_NEEDS   = 4'd3;
    localparam logic [AFTER_W-1:0] INDEX_NEEDS = 4'd1;

    // Largest palette index and color component.
    localparam logic [PARAM_W-1:0] COMP_MAX = 16'd255;

    // Palette offset of the bright colors.
    localparam logic [PARAM_W-1:0] PAL_BRIGHT_OFS = 16'd8;

    // Attribute bit masks.
    localparam logic [ATTR_W-1:0] MASK_BOLD      = 8'h01;
    localparam logic [ATTR_W-1:0] MASK_FAINT     = 8'h02;
    localparam logic [ATTR_W-1:0] MASK_ITALIC    = 8'h04;
    localparam logic [ATTR_W-1:0] MASK_UNDERLINE = 8'h08;
    localparam logic [ATTR_W-1:0] MASK_BLINK     = 8'h10;
    localparam logic [ATTR_W-1:0] MASK_REVERSE   = 8'h20;
    localparam logic [ATTR_W-1:0] MASK_HIDDEN    = 8'h40;
    localparam logic [ATTR_W-1:0] MASK_STRIKE    = 8'h80;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_KIND  = 6'b000010,
        PH_RED   = 6'b000100,
        PH_GREEN = 6'b001000,
        PH_BLUE  = 6'b010000,
        PH_INDEX = 6'b100000
    } t_phase;

    // One parameter beat, param_value in the low bits.
    typedef struct packed {
        logic [AFTER_W-1:0] params_after;
        logic [PARAM_W-1:0] param_value;
    } t_item;

    // One result beat, attr_bits in the low bits.
    typedef struct packed {
        t_status            status;
        logic [COLOR_W-1:0] bg_color;
        logic [COLOR_W-1:0] fg_color;
        logic [ATTR_W-1:0]  attr_bits;
    } t_result;

    // Default colors from the configuration registers.
    typedef struct packed {
        logic [COLOR_W-1:0] default_fg;
        logic [COLOR_W-1:0] default_bg;
    } t_cfg;

endpackage

// ----- rtl/sgrap_cfg.sv -----
`timescale 1ns / 1ps

module sgrap_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output sgrap_pkg::t_cfg     o_cfg
);

    logic [sgrap_pkg::COLOR_W-1:0] r_default_fg;
    logic [sgrap_pkg::COLOR_W-1:0] r_default_bg;
    logic                          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Register write in the access phase; word select on address bit 2.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_fg <= sgrap_pkg::FG_RESET;
            r_default_bg <= sgrap_pkg::BG_RESET;
        end else if (wr_en) begin
            if (paddr[2] == sgrap_pkg::REG_DEFAULT_FG) begin
                r_default_fg <= pwdata[sgrap_pkg::COLOR_W-1:0];
            end else begin
                r_default_bg <= pwdata[sgrap_pkg::COLOR_W-1:0];
            end
        end
    end

    // Read data.
    always_comb begin
        if (paddr[2] == sgrap_pkg::REG_DEFAULT_BG) begin
            prdata = {{(32 - sgrap_pkg::COLOR_W){1'b0}}, r_default_bg};
        end else begin
            prdata = {{(32 - sgrap_pkg::COLOR_W){1'b0}}, r_default_fg};
        end
    end

    assign o_cfg.default_fg = r_default_fg;
    assign o_cfg.default_bg = r_default_bg;

endmodule

// ----- rtl/sgrap_in_reg.sv -----
`timescale 1ns / 1ps

module sgrap_in_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  sgrap_pkg::t_item    i_item,
    input  logic                i_take,
    output logic                o_valid,
    output sgrap_pkg::t_item    o_item
);

    logic             r_valid;
    sgrap_pkg::t_item r_item;

    // Room when empty or when the held beat leaves this cycle.
    assign o_ready = i_rst_n && (!r_valid || i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- rtl/sgrap_exec.sv -----
`timescale 1ns / 1ps

module sgrap_exec (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sgrap_pkg::t_cfg     i_cfg,
    input  logic                i_in_valid,
    input  sgrap_pkg::t_item    i_item,
    output logic                o_take,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sgrap_pkg::t_result  o_result
);

    // Parser state.
    sgrap_pkg::t_phase                r_phase;
    logic                             r_target_bg;
    logic [sgrap_pkg::PARAM_W-1:0]    r_red;
    logic [sgrap_pkg::PARAM_W-1:0]    r_green;
    logic [sgrap_pkg::ATTR_W-1:0]     r_attr;
    logic [sgrap_pkg::COLOR_W-1:0]    r_fg;
    logic [sgrap_pkg::COLOR_W-1:0]    r_bg;

    sgrap_pkg::t_phase                n_phase;
    logic                             n_target_bg;
    logic [sgrap_pkg::PARAM_W-1:0]    n_red;
    logic [sgrap_pkg::PARAM_W-1:0]    n_green;
    logic [sgrap_pkg::ATTR_W-1:0]     n_attr;
    logic [sgrap_pkg::COLOR_W-1:0]    n_fg;
    logic [sgrap_pkg::COLOR_W-1:0]    n_bg;
    sgrap_pkg::t_status               n_status;

    // Result register.
    logic                             r_out_valid;
    sgrap_pkg::t_result               r_out;

    logic [sgrap_pkg::PARAM_W-1:0]    v;
    logic [sgrap_pkg::AFTER_W-1:0]    after;
    logic                             do_plain;
    logic                             put_en;
    logic [sgrap_pkg::COLOR_W-1:0]    put_val;
    logic                             take;

    assign take   = i_in_valid && (!r_out_valid || i_out_ready);
    assign o_take = take;
    assign v      = i_item.param_value;

    // Limit the run length tag.
    always_comb begin
        if (int'(i_item.params_after) > sgrap_pkg::MAX_PARAMS - 1) begin
            after = sgrap_pkg::AFTER_W'(sgrap_pkg::MAX_PARAMS - 1);
        end else begin
            after = i_item.params_after;
        end
    end

    // Phase decode: color operands, kind selection or a plain attribute.
    always_comb begin
        n_phase     = sgrap_pkg::PH_IDLE;
        n_target_bg = r_target_bg;
        n_red       = r_red;
        n_green     = r_green;
        n_attr      = r_attr;
        n_fg        = r_fg;
        n_bg        = r_bg;
        n_status    = sgrap_pkg::ST_OK;
        do_plain    = 1'b0;
        put_en      = 1'b0;
        put_val     = {1'b1, r_red[7:0], r_green[7:0], v[7:0]};

        unique case (r_phase)
            sgrap_pkg::PH_KIND: begin
                if (v == sgrap_pkg::KIND_RGB && after >= sgrap_pkg::RGB_NEEDS) begin
                    n_phase = sgrap_pkg::PH_RED;
                end else if (v == sgrap_pkg::KIND_INDEX &&
                             after >= sgrap_pkg::INDEX_NEEDS) begin
                    n_phase = sgrap_pkg::PH_INDEX;
                end else begin
                    do_plain = 1'b1;
                end
            end
            sgrap_pkg::PH_RED: begin
                n_red   = v;
                n_phase = sgrap_pkg::PH_GREEN;
            end
            sgrap_pkg::PH_GREEN: begin
                n_green = v;
                n_phase = sgrap_pkg::PH_BLUE;
            end
            sgrap_pkg::PH_BLUE: begin
                if (r_red > sgrap_pkg::COMP_MAX || r_green > sgrap_pkg::COMP_MAX ||
                    v > sgrap_pkg::COMP_MAX) begin
                    n_status = sgrap_pkg::ST_RANGE;
                end else begin
                    put_en = 1'b1;
                end
            end
            sgrap_pkg::PH_INDEX: begin
                put_val = sgrap_pkg::COLOR_W'(v);
                if (v > sgrap_pkg::COMP_MAX) begin
                    n_status = sgrap_pkg::ST_RANGE;
                end else begin
                    put_en = 1'b1;
                end
            end
            default: begin
                do_plain = 1'b1;
            end
        endcase

        // Finished extended color goes to the armed target.
        if (put_en) begin
            if (r_target_bg) begin
                n_bg = put_val;
            end else begin
                n_fg = put_val;
            end
        end

        // Ordinary attribute codes.
        if (do_plain) begin
            unique case (v)
                sgrap_pkg::SGR_RESET: begin
                    n_attr = '0;
                    n_fg   = i_cfg.default_fg;
                    n_bg   = i_cfg.default_bg;
                end
                sgrap_pkg::SGR_BOLD:          n_attr = r_attr | sgrap_pkg::MASK_BOLD;
                sgrap_pkg::SGR_FAINT:         n_attr = r_attr | sgrap_pkg::MASK_FAINT;
                sgrap_pkg::SGR_ITALIC:        n_attr = r_attr | sgrap_pkg::MASK_ITALIC;
                sgrap_pkg::SGR_UNDERLINE:     n_attr = r_attr | sgrap_pkg::MASK_UNDERLINE;
                sgrap_pkg::SGR_BLINK_SLOW,
                sgrap_pkg::SGR_BLINK_FAST:    n_attr = r_attr | sgrap_pkg::MASK_BLINK;
                sgrap_pkg::SGR_REVERSE:       n_attr = r_attr | sgrap_pkg::MASK_REVERSE;
                sgrap_pkg::SGR_INVISIBLE:     n_attr = r_attr | sgrap_pkg::MASK_HIDDEN;
                sgrap_pkg::SGR_STRUCK:        n_attr = r_attr | sgrap_pkg::MASK_STRIKE;
                sgrap_pkg::SGR_DBL_UNDERLINE: begin
                    n_attr = r_attr | sgrap_pkg::MASK_UNDERLINE | sgrap_pkg::MASK_STRIKE;
                end
                sgrap_pkg::SGR_NORMAL_INT: begin
                    n_attr = r_attr & ~(sgrap_pkg::MASK_BOLD | sgrap_pkg::MASK_FAINT);
                end
                sgrap_pkg::SGR_NO_ITALIC:     n_attr = r_attr & ~sgrap_pkg::MASK_ITALIC;
                sgrap_pkg::SGR_NO_UNDERLINE:  n_attr = r_attr & ~sgrap_pkg::MASK_UNDERLINE;
                sgrap_pkg::SGR_NO_BLINK:      n_attr = r_attr & ~sgrap_pkg::MASK_BLINK;
                sgrap_pkg::SGR_NO_REVERSE:    n_attr = r_attr & ~sgrap_pkg::MASK_REVERSE;
                sgrap_pkg::SGR_NO_INVISIBLE:  n_attr = r_attr & ~sgrap_pkg::MASK_HIDDEN;
                sgrap_pkg::SGR_NO_STRUCK:     n_attr = r_attr & ~sgrap_pkg::MASK_STRIKE;
                sgrap_pkg::SGR_EXT_FG,
                sgrap_pkg::SGR_EXT_BG: begin
                    if (after == '0) begin
                        n_status = sgrap_pkg::ST_UNKNOWN;
                    end else begin
                        n_target_bg = (v == sgrap_pkg::SGR_EXT_BG);
                        n_phase     = sgrap_pkg::PH_KIND;
                    end
                end
                sgrap_pkg::SGR_DEF_FG:        n_fg = i_cfg.default_fg;
                sgrap_pkg::SGR_DEF_BG:        n_bg = i_cfg.default_bg;
                default: begin
                    // Palette ranges, normal and bright.
                    if (v >= sgrap_pkg::SGR_FG_FIRST && v <= sgrap_pkg::SGR_FG_LAST) begin
                        n_fg = sgrap_pkg::COLOR_W'(v - sgrap_pkg::SGR_FG_FIRST);
                    end else if (v >= sgrap_pkg::SGR_BG_FIRST &&
                                 v <= sgrap_pkg::SGR_BG_LAST) begin
                        n_bg = sgrap_pkg::COLOR_W'(v - sgrap_pkg::SGR_BG_FIRST);
                    end else if (v >= sgrap_pkg::SGR_FG_BRT_FIRST &&
                                 v <= sgrap_pkg::SGR_FG_BRT_LAST) begin
                        n_fg = sgrap_pkg::COLOR_W'(v - sgrap_pkg::SGR_FG_BRT_FIRST +
                                                   sgrap_pkg::PAL_BRIGHT_OFS);
                    end else if (v >= sgrap_pkg::SGR_BG_BRT_FIRST &&
                                 v <= sgrap_pkg::SGR_BG_BRT_LAST) begin
                        n_bg = sgrap_pkg::COLOR_W'(v - sgrap_pkg::SGR_BG_BRT_FIRST +
                                                   sgrap_pkg::PAL_BRIGHT_OFS);
                    end else begin
                        n_status = sgrap_pkg::ST_UNKNOWN;
                    end
                end
            endcase
        end
    end

    // State update, once per taken beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= sgrap_pkg::PH_IDLE;
            r_target_bg <= 1'b0;
            r_red       <= '0;
            r_green     <= '0;
            r_attr      <= '0;
            r_fg        <= sgrap_pkg::FG_RESET;
            r_bg        <= sgrap_pkg::BG_RESET;
        end else if (take) begin
            r_phase     <= n_phase;
            r_target_bg <= n_target_bg;
            r_red       <= n_red;
            r_green     <= n_green;
            r_attr      <= n_attr;
            r_fg        <= n_fg;
            r_bg        <= n_bg;
        end
    end

    // Result register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload shows the state after the beat.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out.attr_bits <= n_attr;
            r_out.fg_color  <= n_fg;
            r_out.bg_color  <= n_bg;
            r_out.status    <= n_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    // The result register always mirrors the state just written.
    a_result_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> (r_out.attr_bits == r_attr && r_out.fg_color == r_fg &&
                  r_out.bg_color == r_bg))
        else $error("result does not match updated state");

    // Taking the red component leaves colors untouched and reports ok.
    a_red_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_phase == sgrap_pkg::PH_RED) |=>
            (r_out.status == sgrap_pkg::ST_OK && r_fg == $past(r_fg) &&
             r_bg == $past(r_bg)))
        else $error("red component step changed a color");

    // A final color operand always returns the parser to idle.
    a_final_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && (r_phase == sgrap_pkg::PH_BLUE || r_phase == sgrap_pkg::PH_INDEX)) |=>
            (r_phase == sgrap_pkg::PH_IDLE))
        else $error("parser not idle after final color operand");

    // Range errors only come from a color operand.
    a_range_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_phase != sgrap_pkg::PH_BLUE && r_phase != sgrap_pkg::PH_INDEX) |=>
            (r_out.status != sgrap_pkg::ST_RANGE))
        else $error("range status outside a color operand");

endmodule

// ----- rtl/sgr_attribute_parser_core.sv -----
`timescale 1ns / 1ps
// A parameter beat passes the input register, then the result register, on its way out.
// One parameter per cycle while the result stream takes results; a full result register
// with tready low stalls the input. The decode of one parameter is combinational, and
// the phase, attribute and color registers update at the edge that takes it.
// Reset (synchronous, active low) clears the parser to idle, attributes to zero,
// colors and default registers to 7 and 0, and empties both registers.

module sgr_attribute_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Parameter stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [15:0] param_value, [19:16] params_after
    // Result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [7:0] attr_bits, [32:8] fg_color,
                                          // [57:33] bg_color, [59:58] status
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    sgrap_pkg::t_cfg    cfg;
    sgrap_pkg::t_item   s_item;
    sgrap_pkg::t_item   held_item;
    sgrap_pkg::t_result result;
    logic               held_valid;
    logic               take;

    assign s_item = i_s_axis_tdata[$bits(sgrap_pkg::t_item)-1:0];

    sgrap_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sgrap_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_item  (s_item),
        .i_take  (take),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    sgrap_exec u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (held_valid),
        .i_item      (held_item),
        .o_take      (take),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_result    (result)
    );

    assign o_m_axis_tdata = {{(64 - $bits(sgrap_pkg::t_result)){1'b0}}, result};

endmodule
